// ===== rtl/inline_raw_html_recognizer_macros.svh =====
// Assertion macros shared by the inline raw HTML recogniser RTL.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef INLINE_RAW_HTML_RECOGNIZER_MACROS_SVH
`define INLINE_RAW_HTML_RECOGNIZER_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define IRH_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define IRH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/irh_pkg.sv =====
// Shared types and constants for the inline raw HTML recogniser.
// No dependencies; imported by every module of the block.
package irh_pkg;

  // Characters the classifier and parser look for.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  // Result status codes.
  localparam logic [1:0] STATUS_MATCH    = 2'd0;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Result kind codes.
  localparam logic [2:0] KIND_COMMENT = 3'd0;
  localparam logic [2:0] KIND_PI      = 3'd1;
  localparam logic [2:0] KIND_CDATA   = 3'd2;
  localparam logic [2:0] KIND_DECL    = 3'd3;
  localparam logic [2:0] KIND_OPEN    = 3'd4;
  localparam logic [2:0] KIND_CLOSE   = 3'd5;

  // Queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic is_zero;
    logic letter;
    logic digit;
    logic ws;
    logic tag_char;
    logic aname_start;
    logic aname_char;
    logic unq_char;
  } class_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
    class_t     cls;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [11:0] match_length;
  } result_t;

  // Expected byte of the "<![CDATA[" opener at a given position.
  function automatic logic [7:0] cdata_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_LT;
      4'd1:    c = CH_BANG;
      4'd2:    c = CH_LBRACK;
      4'd3:    c = 8'h43;  // C
      4'd4:    c = 8'h44;  // D
      4'd5:    c = 8'h41;  // A
      4'd6:    c = 8'h54;  // T
      4'd7:    c = 8'h41;  // A
      4'd8:    c = CH_LBRACK;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/irh_front.sv =====
// Front end: unpacks an incoming word and tags the byte with its character classes.
// Depends on irh_pkg.
module irh_front (
  input  logic           [7:0] ch,
  input  logic                 first,
  input  logic                 last,
  output irh_pkg::item_t       item
);
  import irh_pkg::*;

  logic letter;
  logic digit;
  logic ws;

  always_comb begin
    letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    digit  = (ch >= 8'h30 && ch <= 8'h39);
    ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);

    item.ch    = ch;
    item.first = first;
    item.last  = last;

    item.cls.is_zero     = (ch == CH_NUL);
    item.cls.letter      = letter;
    item.cls.digit       = digit;
    item.cls.ws          = ws;
    item.cls.tag_char    = letter || digit || (ch == CH_DASH);
    item.cls.aname_start = letter || (ch == CH_UNDER) || (ch == CH_COLON);
    item.cls.aname_char  = letter || digit || (ch == CH_UNDER) || (ch == CH_DOT) ||
                           (ch == CH_COLON) || (ch == CH_DASH);
    item.cls.unq_char    = (ch != CH_NUL) && !ws && (ch != CH_DQUOTE) &&
                           (ch != CH_SQUOTE) && (ch != CH_EQ) && (ch != CH_LT) &&
                           (ch != CH_GT) && (ch != CH_BTICK);
  end

endmodule

// ===== rtl/irh_queue.sv =====
// Short queue of classified bytes between front and back ends.
// Depends on irh_pkg and the assertion macro header.
`include "inline_raw_html_recognizer_macros.svh"

module irh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  irh_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_pop,
  output irh_pkg::item_t out_item
);
  import irh_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = !rst && (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  `IRH_ASSERT(a_count_bound, count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count beyond depth")
  `IRH_ASSERT_IMPL(a_pop_nonempty, out_pop, out_valid, "pop requested from empty queue")
  `IRH_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 1'b1, "queue fill lost")

endmodule

// ===== rtl/irh_back.sv =====
// Back end: per-byte recogniser state machine and the result register.
// Depends on irh_pkg and the assertion macro header.
`include "inline_raw_html_recognizer_macros.svh"

module irh_back #(
  parameter int MAX_LENGTH = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  irh_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_ready,
  output irh_pkg::result_t result
);
  import irh_pkg::*;

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int LEN_W = (CNT_W > 12) ? CNT_W : 12;

  localparam logic [4:0] PH_IDLE        = 5'd0;
  localparam logic [4:0] PH_START       = 5'd1;
  localparam logic [4:0] PH_LT          = 5'd2;
  localparam logic [4:0] PH_BANG        = 5'd3;
  localparam logic [4:0] PH_CMT_OPEN    = 5'd4;
  localparam logic [4:0] PH_CMT0        = 5'd5;
  localparam logic [4:0] PH_CMT1        = 5'd6;
  localparam logic [4:0] PH_CMT2        = 5'd7;
  localparam logic [4:0] PH_PI0         = 5'd8;
  localparam logic [4:0] PH_PI1         = 5'd9;
  localparam logic [4:0] PH_CDO         = 5'd10;
  localparam logic [4:0] PH_CD0         = 5'd11;
  localparam logic [4:0] PH_CD1         = 5'd12;
  localparam logic [4:0] PH_CD2         = 5'd13;
  localparam logic [4:0] PH_DECL        = 5'd14;
  localparam logic [4:0] PH_CLOSE_START = 5'd15;
  localparam logic [4:0] PH_CLOSE_NAME  = 5'd16;
  localparam logic [4:0] PH_CLOSE_WS    = 5'd17;
  localparam logic [4:0] PH_TAGNAME     = 5'd18;
  localparam logic [4:0] PH_ATOP        = 5'd19;
  localparam logic [4:0] PH_SLASH       = 5'd20;
  localparam logic [4:0] PH_ANAME       = 5'd21;
  localparam logic [4:0] PH_AFTER_NAME  = 5'd22;
  localparam logic [4:0] PH_AEQ         = 5'd23;
  localparam logic [4:0] PH_DQ          = 5'd24;
  localparam logic [4:0] PH_SQ          = 5'd25;
  localparam logic [4:0] PH_UNQ         = 5'd26;

  localparam logic [1:0] RES_MORE  = 2'd0;
  localparam logic [1:0] RES_FAIL  = 2'd1;
  localparam logic [1:0] RES_MATCH = 2'd2;

  logic [4:0]       phase;
  logic [CNT_W-1:0] byte_count;
  logic             need_separator;
  logic             saw_separator;

  logic [4:0]       phase_next;
  logic [CNT_W-1:0] byte_count_next;
  logic             need_separator_next;
  logic             saw_separator_next;

  logic             emit;
  result_t          res_next;
  logic [1:0]       res;
  logic [2:0]       kind_v;
  logic             run_top;
  logic [CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] len_ext;
  logic [7:0]       c;
  class_t           cl;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign c     = item.ch;
  assign cl    = item.cls;

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    need_separator_next = need_separator;
    saw_separator_next  = saw_separator;
    emit                = 1'b0;
    res_next.status     = STATUS_NO_MATCH;
    res_next.kind       = KIND_COMMENT;
    res_next.match_length = '0;
    res                 = RES_MORE;
    kind_v              = KIND_COMMENT;
    run_top             = 1'b0;

    if (item.first) begin
      phase_next          = PH_START;
      byte_count_next     = '0;
      need_separator_next = 1'b0;
      saw_separator_next  = 1'b0;
    end

    cnt_inc = byte_count_next + 1'b1;
    len_ext = LEN_W'(cnt_inc);

    if (phase_next != PH_IDLE) begin
      if (cl.is_zero) begin
        emit = 1'b1;
      end else if (byte_count_next >= CNT_W'(MAX_LENGTH)) begin
        emit            = 1'b1;
        res_next.status = STATUS_TOO_LONG;
      end else begin
        unique case (phase_next)
          PH_START: begin
            if (c == CH_LT) phase_next = PH_LT;
            else res = RES_FAIL;
          end
          PH_LT: begin
            if (c == CH_BANG) phase_next = PH_BANG;
            else if (c == CH_QMARK) phase_next = PH_PI0;
            else if (c == CH_SLASH) phase_next = PH_CLOSE_START;
            else if (cl.letter) phase_next = PH_TAGNAME;
            else res = RES_FAIL;
          end
          PH_BANG: begin
            if (c == CH_DASH) phase_next = PH_CMT_OPEN;
            else if (c == CH_LBRACK) phase_next = PH_CDO;
            else if (cl.letter) phase_next = PH_DECL;
            else res = RES_FAIL;
          end
          PH_CMT_OPEN: begin
            if (c == CH_DASH) phase_next = PH_CMT0;
            else res = RES_FAIL;
          end
          PH_CMT0, PH_CMT1, PH_CMT2: begin
            if (c == CH_GT && phase_next == PH_CMT2) begin
              res    = RES_MATCH;
              kind_v = KIND_COMMENT;
            end else if (c == CH_DASH) begin
              phase_next = (phase_next == PH_CMT0) ? PH_CMT1 : PH_CMT2;
            end else begin
              phase_next = PH_CMT0;
            end
          end
          PH_PI0, PH_PI1: begin
            if (c == CH_GT && phase_next == PH_PI1) begin
              res    = RES_MATCH;
              kind_v = KIND_PI;
            end else begin
              phase_next = (c == CH_QMARK) ? PH_PI1 : PH_PI0;
            end
          end
          PH_CDO: begin
            if (byte_count_next >= CNT_W'(9) || c != cdata_char(byte_count_next[3:0])) begin
              res = RES_FAIL;
            end else if (byte_count_next == CNT_W'(8)) begin
              phase_next = PH_CD0;
            end
          end
          PH_CD0, PH_CD1, PH_CD2: begin
            if (c == CH_GT && phase_next == PH_CD2) begin
              res    = RES_MATCH;
              kind_v = KIND_CDATA;
            end else if (c == CH_RBRACK) begin
              phase_next = (phase_next == PH_CD0) ? PH_CD1 : PH_CD2;
            end else begin
              phase_next = PH_CD0;
            end
          end
          PH_DECL: begin
            if (c == CH_GT) begin
              res    = RES_MATCH;
              kind_v = KIND_DECL;
            end
          end
          PH_CLOSE_START: begin
            if (cl.letter) phase_next = PH_CLOSE_NAME;
            else res = RES_FAIL;
          end
          PH_CLOSE_NAME, PH_CLOSE_WS: begin
            if (cl.tag_char && phase_next == PH_CLOSE_NAME) begin
              res = RES_MORE;
            end else if (cl.ws) begin
              phase_next = PH_CLOSE_WS;
            end else if (c == CH_GT) begin
              res    = RES_MATCH;
              kind_v = KIND_CLOSE;
            end else begin
              res = RES_FAIL;
            end
          end
          PH_TAGNAME: begin
            if (!cl.tag_char) begin
              need_separator_next = 1'b0;
              saw_separator_next  = 1'b0;
              run_top             = 1'b1;
            end
          end
          PH_ATOP: begin
            run_top = 1'b1;
          end
          PH_SLASH: begin
            if (c == CH_GT) begin
              res    = RES_MATCH;
              kind_v = KIND_OPEN;
            end else begin
              res = RES_FAIL;
            end
          end
          PH_ANAME: begin
            if (cl.aname_char) begin
              res = RES_MORE;
            end else if (cl.ws) begin
              phase_next = PH_AFTER_NAME;
            end else if (c == CH_EQ) begin
              phase_next = PH_AEQ;
            end else begin
              need_separator_next = 1'b1;
              saw_separator_next  = 1'b0;
              run_top             = 1'b1;
            end
          end
          PH_AFTER_NAME: begin
            if (cl.ws) begin
              res = RES_MORE;
            end else if (c == CH_EQ) begin
              phase_next = PH_AEQ;
            end else begin
              // whitespace already seen after the bare name counts as separation
              need_separator_next = 1'b1;
              saw_separator_next  = 1'b1;
              run_top             = 1'b1;
            end
          end
          PH_AEQ: begin
            if (cl.ws) res = RES_MORE;
            else if (c == CH_DQUOTE) phase_next = PH_DQ;
            else if (c == CH_SQUOTE) phase_next = PH_SQ;
            else if (cl.unq_char) phase_next = PH_UNQ;
            else res = RES_FAIL;
          end
          PH_DQ, PH_SQ: begin
            if ((phase_next == PH_DQ && c == CH_DQUOTE) ||
                (phase_next == PH_SQ && c == CH_SQUOTE)) begin
              need_separator_next = 1'b1;
              saw_separator_next  = 1'b0;
              phase_next          = PH_ATOP;
            end
          end
          PH_UNQ: begin
            if (!cl.unq_char) begin
              need_separator_next = 1'b1;
              saw_separator_next  = 1'b0;
              run_top             = 1'b1;
            end
          end
          default: begin
            res = RES_FAIL;
          end
        endcase

        // top of the attribute loop
        if (run_top) begin
          phase_next = PH_ATOP;
          if (cl.ws) begin
            saw_separator_next = 1'b1;
          end else if (c == CH_GT) begin
            res    = RES_MATCH;
            kind_v = KIND_OPEN;
          end else if (c == CH_SLASH) begin
            phase_next = PH_SLASH;
          end else if (need_separator_next && !saw_separator_next) begin
            res = RES_FAIL;
          end else if (cl.aname_start) begin
            phase_next = PH_ANAME;
          end else begin
            res = RES_FAIL;
          end
        end

        byte_count_next = cnt_inc;
        if (res == RES_MATCH) begin
          emit                  = 1'b1;
          res_next.status       = STATUS_MATCH;
          res_next.kind         = kind_v;
          res_next.match_length = len_ext[11:0];
        end else if (res == RES_FAIL || item.last) begin
          emit = 1'b1;
        end
      end
    end

    if (emit) begin
      phase_next          = PH_IDLE;
      need_separator_next = 1'b0;
      saw_separator_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_count     <= '0;
      need_separator <= 1'b0;
      saw_separator  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase          <= phase_next;
        byte_count     <= byte_count_next;
        need_separator <= need_separator_next;
        saw_separator  <= saw_separator_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      result <= res_next;
    end
  end

  `IRH_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready, !q_pop,
                   "result register overwritten while held")
  `IRH_ASSERT_IMPL(a_fail_fields, out_valid && result.status != STATUS_MATCH,
                   result.kind == KIND_COMMENT && result.match_length == 12'd0,
                   "unmatched result carries kind or length")
  `IRH_ASSERT_NEXT(a_emit_idle, q_pop && emit, phase == PH_IDLE && !need_separator,
                   "parser not idle after a decision")

endmodule

// ===== rtl/inline_raw_html_recognizer.sv =====
// Top level of the inline raw HTML recogniser: stream ports, front end, queue, back end.
// Depends on irh_pkg, irh_front, irh_queue and irh_back.
//
// Feed text one byte per word on the slave side, the first byte of an attempt flagged
// in s_tuser and the last byte of the text flagged in s_tlast. The block tells comments,
// processing instructions, CDATA, declarations, closing tags and open tags apart and
// returns one result word per attempt as soon as the answer is known: status
// (0 matched, 1 no match, 2 longer than MAX_LENGTH), kind, and the matched length
// counted from '<' through the terminator (modulo 4096). Bytes that arrive with no
// attempt in progress are dropped without a result; a new first byte abandons an
// attempt silently. Throughput is one byte per cycle while the result register is free
// or being taken: the back-end state machine takes one parse step per byte. An accepted
// byte is written into the two-word queue and is parsed on its way from there into the
// result register. The input stalls only while the result register holds a word that
// the master side has not taken and the queue has filled behind it; it is also held
// off during reset.
module inline_raw_html_recognizer #(
  parameter int MAX_LENGTH = 4095
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: text bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] begin_req
  input  logic        s_tlast,   // end_of_text
  // master side: results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] status, [13:2] match_length, [15:14] zero
  output logic [2:0]  m_tuser    // [2:0] kind
);
  import irh_pkg::*;

  item_t   front_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t result;

  // Classify the byte as it is accepted.
  irh_front u_front (
    .ch    (s_tdata),
    .first (s_tuser),
    .last  (s_tlast),
    .item  (front_item)
  );

  // Decouple acceptance from parsing so a stalled result does not stop the input at once.
  irh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  // Parse one byte per cycle unless a result is stalled; hold it for the master side.
  irh_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .item      (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // Pack the result word: status lowest, length above, pad to two bytes.
  assign m_tdata = {2'b00, result.match_length, result.status};
  assign m_tuser = result.kind;

endmodule

// ===== tb/inline_raw_html_recognizer_tb.sv =====
// Testbench for inline_raw_html_recognizer: streams text bytes in, predicts each result word
// with a local recogniser and checks every word taken from the master side, field by field.
// Depends on irh_pkg and the recogniser RTL.
module inline_raw_html_recognizer_tb;
  import irh_pkg::*;

  localparam int MAX_LEN          = 4095;
  localparam int RANDOM_WORDS     = 2000;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 8;
  localparam logic [71:0] CDATA_OPENER = "<![CDATA[";

  localparam string ALPHA       = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string TAG_CHARS   = "abcxyzQRZ019-";
  localparam string SPACES      = " \t\n\r";
  localparam string ANAME_FIRST = "abkzAKZ_:";
  localparam string ANAME_REST  = "acZ09_.:-";
  localparam string UNQ_CHARS   = "abXZ09/.-_!%&?";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [1:0] status, [13:2] match_length, [15:14] zero
  logic [2:0]  m_tuser;   // [2:0] kind

  inline_raw_html_recognizer #(.MAX_LENGTH(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Local recogniser: one call per accepted word, verdict out when the attempt is decided
  // ---------------------------------------------------------------------------------------
  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_LT, S_BANG, S_CMT_OPEN, S_CMT, S_CMT_D1, S_CMT_D2,
    S_PI, S_PI_Q, S_CD_OPEN, S_CD, S_CD_B1, S_CD_B2, S_DECL,
    S_CLOSE0, S_CLOSE_NAME, S_CLOSE_WS,
    S_TAG, S_ATTR_GAP, S_SLASH, S_ANAME, S_ANAME_WS, S_EQ, S_DQ, S_SQ, S_UNQ
  } parse_state_t;

  typedef enum logic [1:0] {STEP_MORE, STEP_FAIL, STEP_HIT} step_t;

  parse_state_t state;
  logic [15:0]  byte_cnt;
  logic         sep_needed;
  logic         sep_seen;
  logic         settled;

  result_t      pending_verdicts[$];
  logic [7:0]   text_buf[$];

  bit flat_out     = 1'b0;  // no gaps on either side while set
  bit hold_off_req = 1'b0;  // ask the receiver for one long hold-off

  int words_live, results_seen, n_matched, n_rejected, n_too_long, mismatches;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_tagc(input logic [7:0] c);
    return is_alpha(c) || is_num(c) || c == CH_DASH;
  endfunction

  function automatic bit is_aname0(input logic [7:0] c);
    return is_alpha(c) || c == CH_UNDER || c == CH_COLON;
  endfunction

  function automatic bit is_anamec(input logic [7:0] c);
    return is_aname0(c) || is_num(c) || c == CH_DOT || c == CH_DASH;
  endfunction

  function automatic bit is_unquoted(input logic [7:0] c);
    return c != CH_NUL && !is_space(c) && c != CH_DQUOTE && c != CH_SQUOTE &&
           c != CH_EQ && c != CH_LT && c != CH_GT && c != CH_BTICK;
  endfunction

  function automatic void recognizer_reset();
    state      = S_IDLE;
    byte_cnt   = '0;
    sep_needed = 1'b0;
    sep_seen   = 1'b0;
    settled    = 1'b1;
  endfunction

  // Top of the attribute loop inside an open tag.
  function automatic step_t attr_gap(input logic [7:0] c, output logic [2:0] k);
    state = S_ATTR_GAP;
    k = KIND_OPEN;
    if (is_space(c)) begin
      sep_seen = 1'b1;
      return STEP_MORE;
    end
    if (c == CH_GT) return STEP_HIT;
    if (c == CH_SLASH) begin
      state = S_SLASH;
      return STEP_MORE;
    end
    if (sep_needed && !sep_seen) return STEP_FAIL;
    if (is_aname0(c)) begin
      state = S_ANAME;
      return STEP_MORE;
    end
    return STEP_FAIL;
  endfunction

  function automatic step_t close_attr(input logic [7:0] c, input logic sep,
                                       output logic [2:0] k);
    sep_needed = 1'b1;
    sep_seen   = sep;
    return attr_gap(c, k);
  endfunction

  function automatic step_t parse_byte(input logic [7:0] c, input int pos,
                                       output logic [2:0] k);
    k = KIND_COMMENT;
    case (state)
      S_FIRST: begin
        if (c != CH_LT) return STEP_FAIL;
        state = S_LT;
      end
      S_LT: begin
        if (c == CH_BANG) state = S_BANG;
        else if (c == CH_QMARK) state = S_PI;
        else if (c == CH_SLASH) state = S_CLOSE0;
        else if (is_alpha(c)) state = S_TAG;
        else return STEP_FAIL;
      end
      S_BANG: begin
        if (c == CH_DASH) state = S_CMT_OPEN;
        else if (c == CH_LBRACK) state = S_CD_OPEN;
        else if (is_alpha(c)) state = S_DECL;
        else return STEP_FAIL;
      end
      S_CMT_OPEN: begin
        if (c != CH_DASH) return STEP_FAIL;
        state = S_CMT;
      end
      S_CMT, S_CMT_D1, S_CMT_D2: begin
        if (c == CH_GT && state == S_CMT_D2) begin
          k = KIND_COMMENT;
          return STEP_HIT;
        end
        if (c == CH_DASH) state = (state == S_CMT) ? S_CMT_D1 : S_CMT_D2;
        else state = S_CMT;
      end
      S_PI, S_PI_Q: begin
        if (c == CH_GT && state == S_PI_Q) begin
          k = KIND_PI;
          return STEP_HIT;
        end
        state = (c == CH_QMARK) ? S_PI_Q : S_PI;
      end
      S_CD_OPEN: begin
        if (pos >= 9) return STEP_FAIL;
        if (c != CDATA_OPENER[8*(8-pos) +: 8]) return STEP_FAIL;
        if (pos == 8) state = S_CD;
      end
      S_CD, S_CD_B1, S_CD_B2: begin
        if (c == CH_GT && state == S_CD_B2) begin
          k = KIND_CDATA;
          return STEP_HIT;
        end
        if (c == CH_RBRACK) state = (state == S_CD) ? S_CD_B1 : S_CD_B2;
        else state = S_CD;
      end
      S_DECL: begin
        k = KIND_DECL;
        if (c == CH_GT) return STEP_HIT;
      end
      S_CLOSE0: begin
        if (!is_alpha(c)) return STEP_FAIL;
        state = S_CLOSE_NAME;
      end
      S_CLOSE_NAME, S_CLOSE_WS: begin
        k = KIND_CLOSE;
        if (is_space(c)) state = S_CLOSE_WS;
        else if (c == CH_GT) return STEP_HIT;
        else if (!(state == S_CLOSE_NAME && is_tagc(c))) return STEP_FAIL;
      end
      S_TAG: begin
        if (!is_tagc(c)) begin
          sep_needed = 1'b0;
          sep_seen   = 1'b0;
          return attr_gap(c, k);
        end
      end
      S_ATTR_GAP: return attr_gap(c, k);
      S_SLASH: begin
        k = KIND_OPEN;
        return (c == CH_GT) ? STEP_HIT : STEP_FAIL;
      end
      S_ANAME: begin
        if (is_space(c)) state = S_ANAME_WS;
        else if (c == CH_EQ) state = S_EQ;
        else if (!is_anamec(c)) return close_attr(c, 1'b0, k);
      end
      S_ANAME_WS: begin
        // whitespace after a bare name already separates it from the next one
        if (c == CH_EQ) state = S_EQ;
        else if (!is_space(c)) return close_attr(c, 1'b1, k);
      end
      S_EQ: begin
        if (c == CH_DQUOTE) state = S_DQ;
        else if (c == CH_SQUOTE) state = S_SQ;
        else if (is_unquoted(c)) state = S_UNQ;
        else if (!is_space(c)) return STEP_FAIL;
      end
      S_DQ, S_SQ: begin
        if ((state == S_DQ && c == CH_DQUOTE) || (state == S_SQ && c == CH_SQUOTE)) begin
          sep_needed = 1'b1;
          sep_seen   = 1'b0;
          state      = S_ATTR_GAP;
        end
      end
      S_UNQ: begin
        if (!is_unquoted(c)) return close_attr(c, 1'b0, k);
      end
      default: return STEP_FAIL;
    endcase
    return STEP_MORE;
  endfunction

  // Returns 1 when the word decides the attempt; v then holds the expected result word.
  function automatic bit predict_verdict(input logic [7:0] c, input logic first,
                                         input logic fin, output result_t v);
    step_t       r;
    logic [2:0]  k;
    int          pos;
    v = '0;
    if (first) begin
      state      = S_FIRST;
      byte_cnt   = '0;
      sep_needed = 1'b0;
      sep_seen   = 1'b0;
      settled    = 1'b0;
    end
    if (settled) return 1'b0;
    if (c == CH_NUL) begin
      v.status = STATUS_NO_MATCH;
    end else if (byte_cnt >= MAX_LEN) begin
      v.status = STATUS_TOO_LONG;
    end else begin
      pos = int'(byte_cnt);
      byte_cnt = byte_cnt + 16'd1;
      r = parse_byte(c, pos, k);
      if (r == STEP_HIT) begin
        v.status       = STATUS_MATCH;
        v.kind         = k;
        v.match_length = byte_cnt[11:0];
      end else if (r == STEP_FAIL || fin) begin
        v.status = STATUS_NO_MATCH;
      end else begin
        return 1'b0;
      end
    end
    settled    = 1'b1;
    state      = S_IDLE;
    sep_needed = 1'b0;
    sep_seen   = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Idling, sending and the result checker
  // ---------------------------------------------------------------------------------------
  function automatic int idle_length();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return int'($urandom_range(1, 2));
    if (r < 95) return int'($urandom_range(3, 6));
    return int'($urandom_range(10, 30));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offer one word at the falling edge and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] c, input logic first, input logic fin);
    int      gap;
    result_t v;
    gap = (flat_out || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= c;
    s_tuser  <= first;
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (first || !settled) words_live++;
    if (predict_verdict(c, first, fin, v)) pending_verdicts.push_back(v);
  endtask

  // Send the text buffer as one attempt; flag end of text on word fin_at (-1: none).
  task automatic send_text(input int fin_at);
    foreach (text_buf[i]) send_byte(text_buf[i], i == 0, i == fin_at);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_run(input int n, input string pool);
    repeat (n) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
  endtask

  // Free text, leaning on the bytes that matter to the terminator in hot.
  task automatic put_body(input int n, input string hot);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) put_run(1, hot);
      else text_buf.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Receiver: random stalls, none while flat_out is set, one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(negedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (flat_out) begin
        m_tready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_length();
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Compare every word taken from the master side with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %h kind %0d with nothing expected", m_tdata, m_tuser));
      end else begin
        want = pending_verdicts.pop_front();
        results_seen++;
        if (m_tdata[1:0] != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tdata[1:0], want.status));
        if (m_tuser != want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata[13:2] != want.match_length)
          report_mismatch($sformatf("length %0d, expected %0d", m_tdata[13:2],
                                    want.match_length));
        if (m_tdata[15:14] != 2'b00)
          report_mismatch($sformatf("pad bits %b not zero", m_tdata[15:14]));
        case (want.status)
          STATUS_MATCH:    n_matched++;
          STATUS_NO_MATCH: n_rejected++;
          default:         n_too_long++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Corner cases, each in as few words as it takes.
  task automatic test_corner_cases();
    // stray word with no attempt open: drop, no result
    send_byte(8'hFF, 1'b0, 1'b0);
    // first byte not '<'
    send_byte("x", 1'b1, 1'b0);
    // zero byte as a first byte, then mid-attempt
    send_byte(CH_NUL, 1'b1, 1'b0);
    text_buf.delete();
    put_str("<");
    text_buf.push_back(CH_NUL);
    send_text(-1);
    // end of text while still undecided
    text_buf.delete();
    put_str("<a");
    send_text(1);
    // abandon "<!" silently, restart on a closing tag
    text_buf.delete();
    put_str("<!");
    send_text(-1);
    text_buf.delete();
    put_str("</a>");
    send_text(-1);
    // empty unquoted value
    text_buf.delete();
    put_str("<a b=>");
    send_text(-1);
    // slash not followed by '>'
    text_buf.delete();
    put_str("<a/b");
    send_text(-1);
    // whitespace after a bare name separates it from the next attribute
    text_buf.delete();
    put_str("<a b c>");
    send_text(-1);
  endtask

  // Longest comment that still fits, then one byte too many.
  task automatic test_length_limit();
    logic [7:0] b;
    text_buf.delete();
    put_str("<!--");
    while (text_buf.size() < MAX_LEN - 3) begin
      b = 8'($urandom_range(1, 255));
      text_buf.push_back((b == CH_DASH) ? 8'h78 : b);
    end
    put_str("-->");
    send_text(-1);
    text_buf.delete();
    put_str("<!--");
    while (text_buf.size() < MAX_LEN + 1) begin
      b = 8'($urandom_range(1, 255));
      text_buf.push_back((b == CH_DASH) ? 8'h78 : b);
    end
    send_text(-1);
  endtask

  // Hold the receiver off while every word yields a result: the block must stall its input.
  task automatic test_backpressure();
    logic [7:0] b;
    flat_out     = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) begin
      b = 8'($urandom_range(0, 255));
      send_byte((b == CH_LT) ? 8'h41 : b, 1'b1, 1'b0);
    end
    flat_out = 1'b0;
  endtask

  // One attempt: mostly well-formed constructs with random content, the rest noise.
  task automatic compose_attempt();
    int pick;
    pick = int'($urandom_range(0, 99));
    text_buf.delete();
    if (pick < 12) begin
      put_str("<!--");
      put_body(int'($urandom_range(0, 10)), "->");
      put_str("-->");
    end else if (pick < 22) begin
      put_str("<?");
      put_body(int'($urandom_range(0, 10)), "?>");
      put_str("?>");
    end else if (pick < 32) begin
      put_str("<![CDATA[");
      put_body(int'($urandom_range(0, 10)), "]>");
      put_str("]]>");
    end else if (pick < 42) begin
      put_str("<!");
      put_run(1, ALPHA);
      put_body(int'($urandom_range(0, 8)), " >");
      put_str(">");
    end else if (pick < 54) begin
      put_str("</");
      put_run(1, ALPHA);
      put_run(int'($urandom_range(0, 5)), TAG_CHARS);
      put_run(int'($urandom_range(0, 2)), SPACES);
      put_str(">");
    end else if (pick < 88) begin
      put_str("<");
      put_run(1, ALPHA);
      put_run(int'($urandom_range(0, 5)), TAG_CHARS);
      repeat ($urandom_range(0, 3)) begin
        put_run(($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 2)), SPACES);
        put_run(1, ANAME_FIRST);
        put_run(int'($urandom_range(0, 4)), ANAME_REST);
        pick = int'($urandom_range(0, 4));
        if (pick > 0) begin
          put_run(int'($urandom_range(0, 1)), SPACES);
          put_str("=");
          put_run(int'($urandom_range(0, 1)), SPACES);
        end
        case (pick)
          1: begin
            put_str("\"");
            put_body(int'($urandom_range(0, 6)), "'>");
            put_str("\"");
          end
          2: begin
            put_str("'");
            put_body(int'($urandom_range(0, 6)), "\">");
            put_str("'");
          end
          3, 4: put_run(int'($urandom_range(1, 5)), UNQ_CHARS);
          default: ;
        endcase
      end
      put_run(int'($urandom_range(0, 1)), SPACES);
      if ($urandom_range(0, 3) == 0) put_str("/>");
      else put_str(">");
    end else begin
      if ($urandom_range(0, 1) == 1) put_str("<");
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_text();
    int start, fin_at, idx;
    start = words_live;
    while (words_live - start < RANDOM_WORDS) begin
      // an occasional stretch with no idling on either side
      flat_out = ($urandom_range(0, 9) == 0);
      compose_attempt();
      // break some attempts: corrupt one byte, or cut the tail off
      if (text_buf.size() > 1 && $urandom_range(0, 9) == 0) begin
        idx = int'($urandom_range(1, text_buf.size() - 1));
        text_buf[idx] = 8'($urandom_range(0, 255));
      end
      if (text_buf.size() > 1 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, text_buf.size() - 1)) void'(text_buf.pop_back());
      if ($urandom_range(0, 7) == 0) fin_at = int'($urandom_range(0, text_buf.size() - 1));
      else fin_at = -1;
      send_text(fin_at);
      // trailing words: dropped once decided, else they carry the attempt on
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
    flat_out = 1'b0;
  endtask

  // Close the input, wait for every expected word, then give the pipeline a short tail.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_verdicts.size()));
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    recognizer_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_length_limit();
    test_backpressure();
    test_random_text();
    drain_results();
    $display("Sent %0d live text bytes over all forms, corner cases and a full-length attempt.",
             words_live);
    $display("Checked %0d results: %0d matched, %0d rejected, %0d over length; %0d mismatches.",
             results_seen, n_matched, n_rejected, n_too_long, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #60000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/irh_pkg.sv
rtl/irh_front.sv
rtl/irh_queue.sv
rtl/irh_back.sv
rtl/inline_raw_html_recognizer.sv
tb/inline_raw_html_recognizer_tb.sv
